// ----- hw/rtl/ssstat_pkg.sv -----
package ssstat_pkg;

	localparam int VALUE_W     = 16;
	localparam int COUNT_W     = 16;
	localparam int SUM_W       = 32;
	localparam int FRAC_W      = 8;
	localparam int MEAN_W      = 24;
	localparam int ACTION_W    = 2;
	localparam int IN_TDATA_W  = 16;
	localparam int OUT_FIELD_W = 138;
	localparam int OUT_TDATA_W = 144;
	localparam int DIV_CNT_W   = $clog2(MEAN_W);

	localparam logic [ACTION_W-1:0] ACT_ADD   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLOSE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_END   = 2'd2;

	localparam logic KIND_SEGMENT = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic add;
		logic div_start;
		logic load_seg;
		logic seg_last;
		logic close_seg;
		logic load_sum;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic out_free;
	} status_t;

endpackage

// ----- hw/rtl/segmented_stream_statistics_top.sv -----
// Value words: accepted back to back, one per cycle while no close or end word is in progress, no result.
// Close word: the segment report follows the radix-2 divider, which makes one mean bit
// per cycle over 24 bits, and waits for a free output word; input held meanwhile.
// End word: segment report, then the lot summary once the output word is free; then lot state clears.
// Reset: arst_n asynchronous, active low; clears all statistics and the output word.
module segmented_stream_statistics_top
	import ssstat_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value
	input  logic [ACTION_W-1:0]    s_tuser,  // action
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // segment_number, value_count, segment_empty,
	                                         // mean_fixed, segment_minimum, total_segments,
	                                         // lot_maximum, maximum_segment,
	                                         // maximum_position, any_values, zero pad
	output logic                   m_tuser,  // kind
	output logic                   m_tlast
);

	cmd_t    cmd;
	status_t status;

	ssstat_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.action  (s_tuser),
		.status  (status),
		.cmd     (cmd)
	);

	ssstat_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.status  (status),
		.value   (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

endmodule

// ----- hw/rtl/ssstat_div.sv -----
module ssstat_div
	import ssstat_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [COUNT_W-1:0] dividend_hi,
	input  logic [MEAN_W-1:0]  dividend_lo,
	input  logic [COUNT_W-1:0] divisor,
	output logic              done,
	output logic [MEAN_W-1:0]  quotient
);

	logic [COUNT_W-1:0]   rem_q;
	logic [MEAN_W-1:0]    quo_q;
	logic [COUNT_W-1:0]   dvs_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic [COUNT_W:0]     trial;
	logic [COUNT_W:0]     diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[MEAN_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};
	assign done  = busy_q && (cnt_q == DIV_CNT_W'(MEAN_W - 1));
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (done) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend_hi;
			quo_q <= dividend_lo;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
			quo_q <= {quo_q[MEAN_W-2:0], ge};
		end
	end

endmodule

// ----- hw/rtl/ssstat_dp.sv -----
module ssstat_dp
	import ssstat_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [IN_TDATA_W-1:0]  value,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tuser,
	output logic                   m_tlast
);

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] x);
		return (&x) ? x : x + 1'b1;
	endfunction

	logic [SUM_W-1:0]   sum_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [VALUE_W-1:0] min_q;
	logic [COUNT_W-1:0] idx_q;
	logic [VALUE_W-1:0] best_val_q;
	logic [COUNT_W-1:0] best_seg_q;
	logic [COUNT_W-1:0] best_pos_q;
	logic               seen_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic               out_last_q;
	logic [OUT_FIELD_W-1:0] out_data_q;

	logic [VALUE_W-1:0] v;
	logic               take;
	logic [SUM_W:0]     sum_ext;
	logic [COUNT_W-1:0] cnt_next;
	logic [COUNT_W-1:0] number;
	logic               mean_sat;
	logic [MEAN_W-1:0]  mean;
	logic [MEAN_W-1:0]  quotient;
	logic               div_done;

	assign v        = value[VALUE_W-1:0];
	assign take     = cmd.add && (v != '0);
	assign sum_ext  = {1'b0, sum_q} + (SUM_W+1)'(v);
	assign cnt_next = sat_inc(cnt_q);
	assign number   = sat_inc(idx_q);
	assign mean_sat = sum_q[SUM_W-1:SUM_W-COUNT_W] >= cnt_q;

	always_comb begin
		if (cnt_q == '0) begin
			mean = '0;
		end else if (mean_sat) begin
			mean = '1;
		end else begin
			mean = quotient;
		end
	end

	ssstat_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.dividend_hi(sum_q[SUM_W-1:SUM_W-COUNT_W]),
		.dividend_lo({sum_q[SUM_W-COUNT_W-1:0], FRAC_W'(0)}),
		.divisor    (cnt_q),
		.done       (div_done),
		.quotient   (quotient)
	);

	assign status.div_done = div_done;
	assign status.out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			min_q      <= '0;
			idx_q      <= '0;
			best_val_q <= '0;
			best_seg_q <= '0;
			best_pos_q <= '0;
			seen_q     <= 1'b0;
		end else if (cmd.load_sum) begin
			sum_q      <= '0;
			cnt_q      <= '0;
			min_q      <= '0;
			idx_q      <= '0;
			best_val_q <= '0;
			best_seg_q <= '0;
			best_pos_q <= '0;
			seen_q     <= 1'b0;
		end else if (cmd.close_seg) begin
			sum_q <= '0;
			cnt_q <= '0;
			min_q <= '0;
			idx_q <= number;
		end else if (take) begin
			if (cnt_q == '0 || v < min_q) begin
				min_q <= v;
			end
			cnt_q <= cnt_next;
			sum_q <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
			if (!seen_q || v > best_val_q) begin
				best_val_q <= v;
				best_seg_q <= number;
				best_pos_q <= cnt_next;
				seen_q     <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_kind_q  <= KIND_SEGMENT;
			out_last_q  <= 1'b0;
			out_data_q  <= '0;
		end else if (cmd.load_seg) begin
			out_valid_q <= 1'b1;
			out_kind_q  <= KIND_SEGMENT;
			out_last_q  <= cmd.seg_last;
			out_data_q  <= {65'd0, min_q, mean, cnt_q == '0, cnt_q, number};
		end else if (cmd.load_sum) begin
			out_valid_q <= 1'b1;
			out_kind_q  <= KIND_SUMMARY;
			out_last_q  <= 1'b1;
			out_data_q  <= {seen_q, best_pos_q, best_seg_q, best_val_q, number, 73'd0};
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {(OUT_TDATA_W-OUT_FIELD_W)'(0), out_data_q};

endmodule

// ----- hw/rtl/ssstat_ctrl.sv -----
module ssstat_ctrl
	import ssstat_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [ACTION_W-1:0] action,
	input  status_t             status,
	output cmd_t                cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_SEG  = 2'd2;
	localparam logic [1:0] ST_SUM  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       end_q;
	logic       accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd.add = (action == ACT_ADD);
					if (action == ACT_CLOSE || action == ACT_END) begin
						cmd.div_start = 1'b1;
						state_next    = ST_DIV;
					end
				end
			end
			ST_DIV: begin
				if (status.div_done) begin
					state_next = ST_SEG;
				end
			end
			ST_SEG: begin
				if (status.out_free) begin
					cmd.load_seg = 1'b1;
					cmd.seg_last = !end_q;
					if (end_q) begin
						state_next = ST_SUM;
					end else begin
						cmd.close_seg = 1'b1;
						state_next    = ST_IDLE;
					end
				end
			end
			ST_SUM: begin
				if (status.out_free) begin
					cmd.load_sum = 1'b1;
					state_next   = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			end_q   <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.div_start) begin
				end_q <= (action == ACT_END);
			end
		end
	end

endmodule

// ----- hw/rtl/ssstat_chk.sv -----
module ssstat_chk
	import ssstat_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output word changed while stalled");

	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast && m_tdata[72:0] == '0)
		else $error("summary word not last or carries segment fields");

	a_seg_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[OUT_TDATA_W-1:73] == '0)
		else $error("segment word carries summary fields");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[32] == (m_tdata[31:16] == '0))
		else $error("empty flag disagrees with count");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser && !m_tlast |-> !s_tready)
		else $error("input ready while lot summary is pending");

endmodule

bind segmented_stream_statistics_top ssstat_chk u_chk (.*);

// ----- bench/ssstat_checker.sv -----
`timescale 1ns / 1ps
module ssstat_checker
	import ssstat_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // value
	input  logic [ACTION_W-1:0]    s_tuser,  // action
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,  // segment_number, value_count, segment_empty,
	                                         // mean_fixed, segment_minimum, total_segments,
	                                         // lot_maximum, maximum_segment,
	                                         // maximum_position, any_values, zero pad
	input  logic                   m_tuser,  // kind
	input  logic                   m_tlast,
	output int                     fail_count,
	output int                     outstanding,
	output int                     segment_reports,
	output int                     lot_summaries
);

	typedef struct packed {
		logic              kind;
		logic [COUNT_W-1:0] seg_num;
		logic [COUNT_W-1:0] val_cnt;
		logic              empty;
		logic [MEAN_W-1:0]  mean;
		logic [VALUE_W-1:0] seg_min;
		logic [COUNT_W-1:0] total;
		logic [VALUE_W-1:0] lot_max;
		logic [COUNT_W-1:0] max_seg;
		logic [COUNT_W-1:0] max_pos;
		logic              any;
		logic              last;
	} stat_word_t;

	stat_word_t         stat_queue[$];
	logic [SUM_W-1:0]   acc_sum;
	logic [COUNT_W-1:0] seg_len;
	logic [VALUE_W-1:0] seg_low;
	logic [COUNT_W-1:0] seg_closed;
	logic [VALUE_W-1:0] peak_value;
	logic [COUNT_W-1:0] peak_segment;
	logic [COUNT_W-1:0] peak_position;
	logic               peak_seen;

	function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] x);
		return (&x) ? x : x + 1'b1;
	endfunction

	task automatic clear_lot();
		acc_sum       = '0;
		seg_len       = '0;
		seg_low       = '0;
		seg_closed    = '0;
		peak_value    = '0;
		peak_segment  = '0;
		peak_position = '0;
		peak_seen     = 1'b0;
	endtask

	task automatic absorb_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
		stat_word_t                rpt;
		logic [SUM_W:0]            wide_sum;
		logic [SUM_W+FRAC_W-1:0]   quot;
		case (act)
			ACT_ADD: begin
				if (val != '0) begin
					if (seg_len == '0 || val < seg_low)
						seg_low = val;
					seg_len  = bump(seg_len);
					wide_sum = {1'b0, acc_sum} + (SUM_W+1)'(val);
					acc_sum  = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
					if (!peak_seen || val > peak_value) begin
						peak_value    = val;
						peak_segment  = bump(seg_closed);
						peak_position = seg_len;
						peak_seen     = 1'b1;
					end
				end
			end
			ACT_CLOSE, ACT_END: begin
				rpt         = '0;
				rpt.kind    = KIND_SEGMENT;
				rpt.seg_num = bump(seg_closed);
				rpt.val_cnt = seg_len;
				rpt.empty   = (seg_len == '0);
				if (seg_len != '0) begin
					quot        = {acc_sum, {FRAC_W{1'b0}}} / seg_len;
					rpt.mean    = (quot[SUM_W+FRAC_W-1:MEAN_W] != '0) ? '1 : quot[MEAN_W-1:0];
					rpt.seg_min = seg_low;
				end
				rpt.last = (act == ACT_CLOSE);
				stat_queue = {stat_queue, rpt};
				if (act == ACT_CLOSE) begin
					seg_closed = bump(seg_closed);
					acc_sum    = '0;
					seg_len    = '0;
					seg_low    = '0;
				end else begin
					rpt       = '0;
					rpt.kind  = KIND_SUMMARY;
					rpt.total = bump(seg_closed);
					if (peak_seen) begin
						rpt.lot_max = peak_value;
						rpt.max_seg = peak_segment;
						rpt.max_pos = peak_position;
						rpt.any     = 1'b1;
					end
					rpt.last = 1'b1;
					stat_queue = {stat_queue, rpt};
					clear_lot();
				end
			end
			default: ;
		endcase
	endtask

	function automatic void check_field(input string name, input logic [MEAN_W-1:0] want,
	                                    input logic [MEAN_W-1:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	task automatic compare_word();
		stat_word_t want;
		stat_word_t got;
		got = '{kind: m_tuser, seg_num: m_tdata[15:0], val_cnt: m_tdata[31:16],
		        empty: m_tdata[32], mean: m_tdata[56:33], seg_min: m_tdata[72:57],
		        total: m_tdata[88:73], lot_max: m_tdata[104:89], max_seg: m_tdata[120:105],
		        max_pos: m_tdata[136:121], any: m_tdata[137], last: m_tlast};
		if (got.kind == KIND_SUMMARY)
			lot_summaries++;
		else
			segment_reports++;
		if (stat_queue.size() == 0) begin
			fail_count++;
			$display("%0t: unexpected word, expected none actual kind %0d", $time, got.kind);
		end else begin
			want = stat_queue.pop_front();
			check_field("kind", want.kind, got.kind);
			check_field("segment_number", want.seg_num, got.seg_num);
			check_field("value_count", want.val_cnt, got.val_cnt);
			check_field("segment_empty", want.empty, got.empty);
			check_field("mean_fixed", want.mean, got.mean);
			check_field("segment_minimum", want.seg_min, got.seg_min);
			check_field("total_segments", want.total, got.total);
			check_field("lot_maximum", want.lot_max, got.lot_max);
			check_field("maximum_segment", want.max_seg, got.max_seg);
			check_field("maximum_position", want.max_pos, got.max_pos);
			check_field("any_values", want.any, got.any);
			check_field("last", want.last, got.last);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_lot();
			stat_queue.delete();
			fail_count      = 0;
			segment_reports = 0;
			lot_summaries   = 0;
		end else begin
			if (s_tvalid && s_tready)
				absorb_word(s_tuser, s_tdata);
			if (m_tvalid && m_tready)
				compare_word();
		end
		outstanding = stat_queue.size();
	end

endmodule

// ----- bench/tb_segmented_stream_statistics_top.sv -----
`timescale 1ns / 1ps
module tb_segmented_stream_statistics_top;
	import ssstat_pkg::*;

	localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam int IDLE_PCT     = 24;
	localparam int HOLD_CYCLES  = 300;
	localparam int STALL_LIMIT  = 5000;
	localparam int RANDOM_WORDS = 320;
	localparam int DRAIN_CYCLES = 64;
	localparam int LONG_RUN     = 48;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic [ACTION_W-1:0]    s_tuser  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	logic steady  = 1'b0;
	logic hold_go = 1'b0;
	int   quiet_cycles = 0;
	int   words_sent   = 0;
	int   fail_count;
	int   outstanding;
	int   segment_reports;
	int   lot_summaries;

	always #5 clk = ~clk;

	segmented_stream_statistics_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ssstat_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tuser         (s_tuser),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tuser         (m_tuser),
		.m_tlast         (m_tlast),
		.fail_count      (fail_count),
		.outstanding     (outstanding),
		.segment_reports (segment_reports),
		.lot_summaries   (lot_summaries)
	);

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles with no word moving", quiet_cycles);
			$display("segmented_stream_statistics_top verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : result_sink
		bit hold_taken;
		hold_taken = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_go && !hold_taken) begin
				hold_taken = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	task automatic send_word(input logic [ACTION_W-1:0] act, input logic [VALUE_W-1:0] val);
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		words_sent++;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(9))
			0: return '1;
			1: return 16'd1;
			2: return 16'($urandom_range(16, 1));
			3: return 16'hFFFE;
			default: return 16'($urandom_range(16'hFFFF, 1));
		endcase
	endfunction

	initial begin : stimulus
		int roll;
		int counted;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty lot, empty segment, ignored words
		send_word(ACT_END, '0);
		send_word(ACT_CLOSE, '0);
		send_word(ACT_ADD, '0);
		send_word(ACT_SPARE, '1);
		// extremes and ties for the maximum
		send_word(ACT_ADD, '1);
		send_word(ACT_ADD, 16'd1);
		send_word(ACT_ADD, '1);
		send_word(ACT_ADD, 16'h8000);
		send_word(ACT_CLOSE, '0);
		send_word(ACT_ADD, 16'h5555);
		send_word(ACT_ADD, 16'hAAAA);
		send_word(ACT_ADD, '1);
		send_word(ACT_CLOSE, '0);
		send_word(ACT_CLOSE, '0);
		send_word(ACT_END, '0);
		send_word(ACT_ADD, 16'd7);
		send_word(ACT_ADD, 16'd3);
		send_word(ACT_END, '0);

		// back to back run of large values in one segment
		steady = 1'b1;
		repeat (LONG_RUN) send_word(ACT_ADD, 16'hFFFE);
		send_word(ACT_ADD, '1);
		send_word(ACT_CLOSE, '0);
		send_word(ACT_ADD, 16'd1);
		send_word(ACT_END, '0);
		steady = 1'b0;

		counted = 0;
		while (counted < RANDOM_WORDS) begin
			if (counted == 150)
				hold_go = 1'b1;
			steady = (counted >= 200 && counted < 260);
			if (counted == 300) begin
				while (outstanding != 0) @(negedge clk);
			end
			roll = $urandom_range(99);
			if (roll < 3) begin
				send_word(ACT_ADD, '0);
			end else if (roll < 6) begin
				send_word(ACT_SPARE, 16'($urandom));
			end else begin
				if (roll < 78)
					send_word(ACT_ADD, pick_value());
				else if (roll < 92)
					send_word(ACT_CLOSE, 16'($urandom));
				else
					send_word(ACT_END, 16'($urandom));
				counted++;
			end
		end
		send_word(ACT_END, '0);
		steady = 1'b0;

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("sent %0d words including a %0d value segment; checked %0d segment reports",
		         words_sent, LONG_RUN + 1, segment_reports);
		$display("and %0d lot summaries with %0d field mismatches", lot_summaries, fail_count);
		if (fail_count == 0)
			$display("segmented_stream_statistics_top verification clean");
		else
			$display("segmented_stream_statistics_top verification failed");
		$finish;
	end

endmodule

// ----- segmented_stream_statistics_top.f -----
hw/rtl/ssstat_pkg.sv
hw/rtl/ssstat_div.sv
hw/rtl/ssstat_dp.sv
hw/rtl/ssstat_ctrl.sv
hw/rtl/segmented_stream_statistics_top.sv
hw/rtl/ssstat_chk.sv
bench/ssstat_checker.sv
bench/tb_segmented_stream_statistics_top.sv
